>>> design/qspe_pkg.sv
package qspe_pkg;

  localparam int MAX_NODES_DEF  = 1024;
  localparam int MAX_EDGES_DEF  = 4096;
  localparam int FUNC_W         = 2;
  localparam int NODE_W         = 10;
  localparam int WEIGHT_W       = 16;
  localparam int DIST_W         = 32;
  localparam int NCFG_W         = 11;
  localparam logic [NCFG_W-1:0] NODE_COUNT_RST = 11'd1024;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0]          a;
    logic [NODE_W-1:0]          b;
    logic signed [WEIGHT_W-1:0] w;
  } edge_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_POP,
    S_FETCH,
    S_CUR,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_RELAX,
    S_REPORT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic add_edge;
    logic clear_edges;
    logic start;
    logic clr_step;
    logic seed;
    logic pop_rd;
    logic fetch;
    logic cur_ld;
    logic edge_rd;
    logic edge_chk;
    logic relax;
    logic rpt_rd;
    logic result_ld;
  } cmd_t;

  typedef struct packed {
    logic bad_in;
    logic clr_done;
    logic cnt_zero;
    logic idx_done;
    logic match;
    logic neg_hit;
    logic out_free;
  } stat_t;

endpackage

>>> design/qspe_if.sv
interface qspe_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [qspe_pkg::FUNC_W-1:0]           func;
  logic [qspe_pkg::NODE_W-1:0]           node_a;
  logic [qspe_pkg::NODE_W-1:0]           node_b;
  logic signed [qspe_pkg::WEIGHT_W-1:0]  weight;
  logic [qspe_pkg::NODE_W-1:0]           source_node;
  logic [qspe_pkg::NODE_W-1:0]           target_node;

  modport source (output valid, func, node_a, node_b, weight, source_node, target_node,
                  input ready);
  modport sink   (input valid, func, node_a, node_b, weight, source_node, target_node,
                  output ready);
endinterface

interface qspe_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qspe_pkg::DIST_W-1:0]  distance;
  logic                                reachable;
  logic                                negative_cycle;
  logic                                edge_overflow;

  modport source (output valid, distance, reachable, negative_cycle, edge_overflow,
                  input ready);
  modport sink   (input valid, distance, reachable, negative_cycle, edge_overflow,
                  output ready);
endinterface

>>> design/queue_shortest_path_engine.sv
// Shortest-path engine: SPFA (queue Bellman-Ford) over an undirected edge list.
// in_req carries requests: func ADD appends an edge, CLEAR empties the list,
// SEARCH runs from min(source,target) and reports distance to the other node.
// out_rsp carries one response per SEARCH: distance, reachable,
// negative_cycle, edge_overflow. ADD and CLEAR produce no response.
// cfg_we/cfg_wdata write node_count; write it only while the engine is idle.
// ADD and CLEAR are taken in the idle state, so edges load at one per cycle while no SEARCH is busy.
// SEARCH holds in_req.ready low until done. After it is accepted the engine
// clears n node-table entries (n = node_count, clamped to 1..MAX_NODES), seeds
// the source, then per dequeued node pops, fetches and loads it and scans every
// stored edge with a read and a check, relaxing each in-range edge touching it;
// then it sees the empty queue, reads the target and loads the response.
// A detected negative cycle ends the scan at that edge and goes to the read.
// The single node-table port and the serial edge scan set the search time.
// An out-of-range endpoint skips the search and loads its response directly.
// After reset the edge list is empty, node_count is 1024, no response pending.
// A stalled response sits in the output register while ADD/CLEAR requests are
// still taken; a later SEARCH finishes and keeps in_req.ready low until it frees.
module queue_shortest_path_engine #(
  parameter int MAX_NODES = qspe_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = qspe_pkg::MAX_EDGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  qspe_in_if.sink                     in_req,
  qspe_out_if.source                  out_rsp,
  input  logic                        cfg_we,
  input  logic [qspe_pkg::NCFG_W-1:0] cfg_wdata
);
  import qspe_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  qspe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_func  (in_req.func),
    .stat     (stat),
    .in_ready (in_req.ready),
    .cmd      (cmd)
  );

  qspe_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_node_a          (in_req.node_a),
    .in_node_b          (in_req.node_b),
    .in_weight          (in_req.weight),
    .in_source_node     (in_req.source_node),
    .in_target_node     (in_req.target_node),
    .cmd                (cmd),
    .stat               (stat),
    .out_ready          (out_rsp.ready),
    .out_valid          (out_rsp.valid),
    .out_distance       (out_rsp.distance),
    .out_reachable      (out_rsp.reachable),
    .out_negative_cycle (out_rsp.negative_cycle),
    .out_edge_overflow  (out_rsp.edge_overflow)
  );

  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !in_req.ready)
    else $error("input still ready after a search started");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_ld |-> (!out_rsp.valid || out_rsp.ready))
    else $error("response loaded over a pending one");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_ld |=> out_rsp.valid)
    else $error("loaded response not presented");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.add_edge, cmd.clear_edges, cmd.start, cmd.relax, cmd.result_ld,
              cmd.clr_step}))
    else $error("conflicting datapath commands");

endmodule

>>> design/qspe_ctrl.sv
module qspe_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [qspe_pkg::FUNC_W-1:0] in_func,
  input  qspe_pkg::stat_t             stat,
  output logic                        in_ready,
  output qspe_pkg::cmd_t              cmd
);
  import qspe_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_func == FUNC_SEARCH) begin
          state_nxt = stat.bad_in ? S_RESULT : S_CLEAR;
        end
      end
      S_CLEAR:    if (stat.clr_done) state_nxt = S_SEED;
      S_SEED:     state_nxt = S_POP;
      S_POP:      state_nxt = stat.cnt_zero ? S_REPORT : S_FETCH;
      S_FETCH:    state_nxt = S_CUR;
      S_CUR:      state_nxt = S_EDGE_RD;
      S_EDGE_RD:  state_nxt = stat.idx_done ? S_POP : S_EDGE_CHK;
      S_EDGE_CHK: state_nxt = stat.match ? S_RELAX : S_EDGE_RD;
      S_RELAX:    state_nxt = stat.neg_hit ? S_REPORT : S_EDGE_RD;
      S_REPORT:   state_nxt = S_RESULT;
      S_RESULT:   if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready        = 1'b1;
        cmd.add_edge    = in_valid && in_func == FUNC_ADD;
        cmd.clear_edges = in_valid && in_func == FUNC_CLEAR;
        cmd.start       = in_valid && in_func == FUNC_SEARCH;
      end
      S_CLEAR:    cmd.clr_step  = 1'b1;
      S_SEED:     cmd.seed      = 1'b1;
      S_POP:      cmd.pop_rd    = !stat.cnt_zero;
      S_FETCH:    cmd.fetch     = 1'b1;
      S_CUR:      cmd.cur_ld    = 1'b1;
      S_EDGE_RD:  cmd.edge_rd   = !stat.idx_done;
      S_EDGE_CHK: cmd.edge_chk  = 1'b1;
      S_RELAX:    cmd.relax     = 1'b1;
      S_REPORT:   cmd.rpt_rd    = 1'b1;
      S_RESULT:   cmd.result_ld = stat.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

>>> design/qspe_dp.sv
module qspe_dp #(
  parameter int MAX_NODES = qspe_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = qspe_pkg::MAX_EDGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [qspe_pkg::NCFG_W-1:0]         cfg_wdata,
  input  logic [qspe_pkg::NODE_W-1:0]         in_node_a,
  input  logic [qspe_pkg::NODE_W-1:0]         in_node_b,
  input  logic signed [qspe_pkg::WEIGHT_W-1:0] in_weight,
  input  logic [qspe_pkg::NODE_W-1:0]         in_source_node,
  input  logic [qspe_pkg::NODE_W-1:0]         in_target_node,
  input  qspe_pkg::cmd_t                      cmd,
  output qspe_pkg::stat_t                     stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [qspe_pkg::DIST_W-1:0]  out_distance,
  output logic                                out_reachable,
  output logic                                out_negative_cycle,
  output logic                                out_edge_overflow
);
  import qspe_pkg::*;

  localparam int NW     = $clog2(MAX_NODES);
  localparam int NCW    = $clog2(MAX_NODES + 1);
  localparam int CW     = (NCW > NCFG_W) ? NCW : NCFG_W;
  localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW    = $clog2(MAX_EDGES + 1);
  localparam int TW     = NCW;
  localparam int NREC_W = DIST_W + 2 + TW;
  localparam logic [CW-1:0]  MAXN_C    = CW'(MAX_NODES);
  localparam logic [NCW-1:0] MAXN_Q    = NCW'(MAX_NODES);
  localparam logic [NW-1:0]  LAST_SLOT = NW'(MAX_NODES - 1);
  localparam logic [ETW-1:0] MAXE_C    = ETW'(MAX_EDGES);

  // node record: {dist, reached, queued, tally}
  logic [NREC_W-1:0] node_mem [MAX_NODES];
  logic [NREC_W-1:0] nrd_r;
  edge_t             edge_mem [MAX_EDGES];
  edge_t             erd_r;
  logic [NW-1:0]     fifo_mem [MAX_NODES];
  logic [NW-1:0]     frd_r;

  logic [NCFG_W-1:0]       ncount_r;
  logic [ETW-1:0]          etotal_r;
  logic                    dropped_r;
  logic [CW-1:0]           n_r;
  logic [NW-1:0]           s_r, t_r;
  logic                    bad_r;
  logic [NW-1:0]           clr_idx_r;
  logic [NW-1:0]           head_r, tail_r;
  logic [NCW-1:0]          qcnt_r;
  logic [NW-1:0]           cur_r;
  logic signed [DIST_W-1:0] dcur_r;
  logic [ETW-1:0]          eidx_r;
  logic [NW-1:0]           v_r;
  logic signed [DIST_W-1:0] cand_r;
  logic                    neg_r;

  logic                    res_valid_r;
  logic signed [DIST_W-1:0] res_dist_r;
  logic                    res_reach_r, res_neg_r, res_ovf_r;

  function automatic logic [NW-1:0] wrap_inc(input logic [NW-1:0] x);
    wrap_inc = (x == LAST_SLOT) ? '0 : x + 1'b1;
  endfunction

  // search start
  logic [CW-1:0]     cfg_ext, n_eff;
  logic [NODE_W-1:0] s_in, t_in;
  logic              bad_in;

  always_comb begin
    cfg_ext = CW'(ncount_r);
    if (cfg_ext == '0) begin
      n_eff = CW'(1);
    end else if (cfg_ext > MAXN_C) begin
      n_eff = MAXN_C;
    end else begin
      n_eff = cfg_ext;
    end
    s_in   = (in_source_node > in_target_node) ? in_target_node : in_source_node;
    t_in   = (in_source_node > in_target_node) ? in_source_node : in_target_node;
    bad_in = CW'(t_in) >= n_eff;
  end

  // node record fields
  logic signed [DIST_W-1:0] nd_dist;
  logic                     nd_reached, nd_queued;
  logic [TW-1:0]            nd_tally;
  assign {nd_dist, nd_reached, nd_queued, nd_tally} = nrd_r;

  // edge check
  logic              a_ok, b_ok, is_a, is_b, match;
  logic [NW-1:0]     v_c;
  logic signed [DIST_W:0] sum_c;
  logic signed [DIST_W-1:0] cand_c;

  always_comb begin
    a_ok  = CW'(erd_r.a) < n_r;
    b_ok  = CW'(erd_r.b) < n_r;
    is_b  = CW'(cur_r) == CW'(erd_r.b);
    is_a  = CW'(cur_r) == CW'(erd_r.a);
    match = a_ok && b_ok && (is_a || is_b);
    v_c   = is_b ? NW'(erd_r.a) : NW'(erd_r.b);
    sum_c = {dcur_r[DIST_W-1], dcur_r} + (DIST_W+1)'(erd_r.w);
    if (sum_c[DIST_W] != sum_c[DIST_W-1]) begin
      cand_c = sum_c[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      cand_c = sum_c[DIST_W-1:0];
    end
  end

  // relaxation
  logic          upd, enq, neg_hit;
  logic [TW-1:0] tally_inc;
  always_comb begin
    upd       = !nd_reached || (cand_r < nd_dist);
    enq       = upd && !nd_queued && (qcnt_r < MAXN_Q);
    tally_inc = nd_tally + 1'b1;
    neg_hit   = cmd.relax && enq && (CW'(tally_inc) >= n_r);
  end

  // node memory port
  logic              nwe;
  logic [NW-1:0]     nwa;
  logic [NREC_W-1:0] nwd;
  logic              nre;
  logic [NW-1:0]     nra;

  always_comb begin
    nwe = 1'b0;
    nwa = clr_idx_r;
    nwd = '0;
    priority if (cmd.clr_step) begin
      nwe = 1'b1;
    end else if (cmd.seed) begin
      nwe = 1'b1;
      nwa = s_r;
      nwd = {{DIST_W{1'b0}}, 1'b1, 1'b1, {TW{1'b0}}};
    end else if (cmd.cur_ld) begin
      nwe = 1'b1;
      nwa = cur_r;
      nwd = {nd_dist, nd_reached, 1'b0, nd_tally};
    end else if (cmd.relax) begin
      nwe = upd;
      nwa = v_r;
      nwd = enq ? {cand_r, 1'b1, 1'b1, tally_inc} : {cand_r, 1'b1, nd_queued, nd_tally};
    end
    nre = cmd.fetch || cmd.edge_chk || cmd.rpt_rd;
    priority if (cmd.fetch)         nra = frd_r;
    else if (cmd.edge_chk)          nra = v_c;
    else                            nra = t_r;
  end

  always_ff @(posedge clk) begin
    if (nwe) node_mem[nwa] <= nwd;
    if (nre) nrd_r <= node_mem[nra];
  end

  // edge memory
  always_ff @(posedge clk) begin
    if (cmd.add_edge && etotal_r < MAXE_C) begin
      edge_mem[EAW'(etotal_r)] <= '{a: in_node_a, b: in_node_b, w: in_weight};
    end
    if (cmd.edge_rd) erd_r <= edge_mem[EAW'(eidx_r)];
  end

  // work queue
  logic          fwe;
  logic [NW-1:0] fwd;
  assign fwe = cmd.seed || (cmd.relax && enq);
  assign fwd = cmd.seed ? s_r : v_r;

  always_ff @(posedge clk) begin
    if (fwe) fifo_mem[tail_r] <= fwd;
    if (cmd.pop_rd) frd_r <= fifo_mem[head_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncount_r  <= NODE_COUNT_RST;
      etotal_r  <= '0;
      dropped_r <= 1'b0;
      head_r    <= '0;
      tail_r    <= '0;
      qcnt_r    <= '0;
      neg_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_we) ncount_r <= cfg_wdata;
      if (cmd.add_edge) begin
        if (etotal_r < MAXE_C) etotal_r <= etotal_r + 1'b1;
        else                   dropped_r <= 1'b1;
      end
      if (cmd.clear_edges) begin
        etotal_r  <= '0;
        dropped_r <= 1'b0;
      end
      if (cmd.start) begin
        head_r <= '0;
        tail_r <= '0;
        qcnt_r <= '0;
        neg_r  <= 1'b0;
      end
      if (cmd.seed) begin
        tail_r <= wrap_inc(tail_r);
        qcnt_r <= NCW'(1);
      end
      if (cmd.fetch) begin
        head_r <= wrap_inc(head_r);
        qcnt_r <= qcnt_r - 1'b1;
      end
      if (cmd.relax && enq) begin
        tail_r <= wrap_inc(tail_r);
        qcnt_r <= qcnt_r + 1'b1;
      end
      if (neg_hit) neg_r <= 1'b1;
      if (cmd.result_ld)   res_valid_r <= 1'b1;
      else if (out_ready)  res_valid_r <= 1'b0;
    end
  end

  // search datapath registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r       <= n_eff;
      s_r       <= NW'(s_in);
      t_r       <= NW'(t_in);
      bad_r     <= bad_in;
      clr_idx_r <= '0;
    end
    if (cmd.clr_step) clr_idx_r <= clr_idx_r + 1'b1;
    if (cmd.fetch) cur_r <= frd_r;
    if (cmd.cur_ld) begin
      dcur_r <= nd_dist;
      eidx_r <= '0;
    end
    if (cmd.edge_chk) begin
      v_r    <= v_c;
      cand_r <= cand_c;
      if (!match) eidx_r <= eidx_r + 1'b1;
    end
    if (cmd.relax) begin
      eidx_r <= eidx_r + 1'b1;
      // a self-loop can lower the node being expanded
      if (upd && v_r == cur_r) dcur_r <= cand_r;
    end
    if (cmd.result_ld) begin
      res_reach_r <= !bad_r && nd_reached;
      res_dist_r  <= (!bad_r && nd_reached) ? nd_dist : '0;
      res_neg_r   <= !bad_r && neg_r;
      res_ovf_r   <= dropped_r;
    end
  end

  always_comb begin
    stat.bad_in   = bad_in;
    stat.clr_done = CW'(clr_idx_r) == (n_r - 1'b1);
    stat.cnt_zero = qcnt_r == '0;
    stat.idx_done = eidx_r == etotal_r;
    stat.match    = match;
    stat.neg_hit  = neg_hit;
    stat.out_free = !res_valid_r || out_ready;
  end

  assign out_valid          = res_valid_r;
  assign out_distance       = res_dist_r;
  assign out_reachable      = res_reach_r;
  assign out_negative_cycle = res_neg_r;
  assign out_edge_overflow  = res_ovf_r;

endmodule

>>> bench/queue_shortest_path_engine_tb.sv
module queue_shortest_path_engine_tb;
  import qspe_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [FUNC_W-1:0]          func;
    logic [NODE_W-1:0]          a;
    logic [NODE_W-1:0]          b;
    logic signed [WEIGHT_W-1:0] w;
    logic [NODE_W-1:0]          s;
    logic [NODE_W-1:0]          t;
  } path_req_t;

  typedef struct {
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     negative_cycle;
    logic                     edge_overflow;
  } path_result_t;

  typedef struct {
    path_req_t    req;
    bit           typed;
    path_result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [NCFG_W-1:0] cfg_wdata;

  qspe_in_if  in_if();
  qspe_out_if out_if();

  queue_shortest_path_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_if),
    .out_rsp   (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the engine
  logic [NODE_W-1:0] edge_a [MAX_EDGES_DEF];
  logic [NODE_W-1:0] edge_b [MAX_EDGES_DEF];
  int                edge_w [MAX_EDGES_DEF];
  int                edge_cnt;
  bit                edge_dropped;
  int unsigned       node_cfg;

  int  node_dist  [MAX_NODES_DEF];
  bit  node_seen  [MAX_NODES_DEF];
  bit  node_inq   [MAX_NODES_DEF];
  int  node_tally [MAX_NODES_DEF];
  int  work_q     [MAX_NODES_DEF];

  path_result_t pending_results[$];
  int  mismatches;
  int  quiet_cycles;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_cycles;

  function automatic int sat_add(int x, int y);
    longint sum;
    sum = longint'(x) + longint'(y);
    if (sum > 64'sd2147483647) return 32'sh7fffffff;
    if (sum < -64'sd2147483648) return 32'sh80000000;
    return int'(sum);
  endfunction

  function automatic int eff_nodes();
    if (node_cfg == 0) return 1;
    if (node_cfg > MAX_NODES_DEF) return MAX_NODES_DEF;
    return node_cfg;
  endfunction

  // SPFA; returns 1 when a node is queued n times
  function automatic bit spfa_run(int n, int src);
    int head;
    int cnt;
    int cur;
    int v;
    int cand;
    head = 0;
    for (int i = 0; i < n; i++) begin
      node_dist[i] = 0;
      node_seen[i] = 0;
      node_inq[i] = 0;
      node_tally[i] = 0;
    end
    node_seen[src] = 1;
    node_inq[src] = 1;
    work_q[0] = src;
    cnt = 1;
    while (cnt > 0) begin
      cur = work_q[head];
      head = (head + 1) % MAX_NODES_DEF;
      cnt--;
      node_inq[cur] = 0;
      for (int i = 0; i < edge_cnt; i++) begin
        if (edge_a[i] >= n || edge_b[i] >= n) continue;
        if (cur == edge_b[i]) v = edge_a[i];
        else if (cur == edge_a[i]) v = edge_b[i];
        else continue;
        cand = sat_add(node_dist[cur], edge_w[i]);
        if (!node_seen[v] || cand < node_dist[v]) begin
          node_dist[v] = cand;
          node_seen[v] = 1;
          if (!node_inq[v] && cnt < MAX_NODES_DEF) begin
            work_q[(head + cnt) % MAX_NODES_DEF] = v;
            cnt++;
            node_inq[v] = 1;
            node_tally[v]++;
            if (node_tally[v] >= n) return 1;
          end
        end
      end
    end
    return 0;
  endfunction

  function automatic path_result_t predict_path(path_req_t r);
    path_result_t res;
    int n;
    int lo;
    int hi;
    n = eff_nodes();
    lo = (r.s < r.t) ? r.s : r.t;
    hi = (r.s < r.t) ? r.t : r.s;
    res.distance = '0;
    res.reachable = 0;
    res.negative_cycle = 0;
    res.edge_overflow = edge_dropped;
    if (lo < n && hi < n) begin
      res.negative_cycle = spfa_run(n, lo);
      if (node_seen[hi]) begin
        res.reachable = 1;
        res.distance = node_dist[hi];
      end
    end
    return res;
  endfunction

  task automatic apply_req(path_req_t r, bit typed, path_result_t e);
    case (r.func)
      FUNC_ADD: begin
        if (edge_cnt < MAX_EDGES_DEF) begin
          edge_a[edge_cnt] = r.a;
          edge_b[edge_cnt] = r.b;
          edge_w[edge_cnt] = r.w;
          edge_cnt++;
        end else begin
          edge_dropped = 1;
        end
      end
      FUNC_CLEAR: begin
        edge_cnt = 0;
        edge_dropped = 0;
      end
      FUNC_SEARCH: pending_results.push_back(typed ? e : predict_path(r));
      default: ;
    endcase
  endtask

  task automatic send_req(path_req_t r, bit typed = 0, path_result_t e = '{default: 0});
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= r.func;
    in_if.node_a      <= r.a;
    in_if.node_b      <= r.b;
    in_if.weight      <= r.w;
    in_if.source_node <= r.s;
    in_if.target_node <= r.t;
    do @(posedge clk); while (!in_if.ready);
    apply_req(r, typed, e);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(int unsigned v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[NCFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    node_cfg = v & 32'h7ff;
    @(posedge clk);
  endtask

  function automatic path_req_t mk_req(logic [FUNC_W-1:0] f, int a, int b, int w, int s,
                                       int t);
    path_req_t r;
    r.func = f;
    r.a = a;
    r.b = b;
    r.w = w;
    r.s = s;
    r.t = t;
    return r;
  endfunction

  function automatic int pick_node();
    if ($urandom_range(99) < 85) return $urandom_range(eff_nodes() - 1);
    return $urandom_range(MAX_NODES_DEF - 1);
  endfunction

  function automatic int pick_weight(bit neg_ok);
    if (!neg_ok) return ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(50);
    if ($urandom_range(9) == 0) return $signed(16'($urandom()));
    return $urandom_range(200) - 40;
  endfunction

  function automatic path_req_t rand_edge(bit neg_ok);
    return mk_req(FUNC_ADD, pick_node(), pick_node(), pick_weight(neg_ok),
                  $urandom_range(1023), $urandom_range(1023));
  endfunction

  function automatic path_req_t rand_search();
    return mk_req(FUNC_SEARCH, $urandom_range(1023), $urandom_range(1023),
                  $signed(16'($urandom())), pick_node(), pick_node());
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // response side: stall pattern plus the long hold-off
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    path_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: dist=%0d reach=%0b neg=%0b ovf=%0b",
                   out_if.distance, out_if.reachable, out_if.negative_cycle,
                   out_if.edge_overflow);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.distance !== exp_r.distance || out_if.reachable !== exp_r.reachable ||
            out_if.negative_cycle !== exp_r.negative_cycle ||
            out_if.edge_overflow !== exp_r.edge_overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: exp dist=%0d reach=%0b neg=%0b ovf=%0b, got dist=%0d reach=%0b neg=%0b ovf=%0b",
                     exp_r.distance, exp_r.reachable, exp_r.negative_cycle,
                     exp_r.edge_overflow, out_if.distance, out_if.reachable,
                     out_if.negative_cycle, out_if.edge_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("queue_shortest_path_engine: mismatch");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    int unsigned ph_nodes[6];
    bit ph_neg[6];
    int ph_idle[4];
    int ph_stall[4];
    int sent;
    int k;

    ph_nodes = '{4, 16, 0, 1024, 2047, 9};
    ph_neg   = '{1, 1, 1, 0, 0, 1};
    ph_idle  = '{0, 61, 0, 21};
    ph_stall = '{0, 0, 61, 21};

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.func = FUNC_ADD;
    in_if.node_a = '0;
    in_if.node_b = '0;
    in_if.weight = '0;
    in_if.source_node = '0;
    in_if.target_node = '0;
    mismatches = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    edge_cnt = 0;
    edge_dropped = 0;
    node_cfg = NODE_COUNT_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows.push_back('{mk_req(FUNC_SEARCH, 0, 0, 0, 0, 0), 1, '{0, 1, 0, 0}});
    dir_rows.push_back('{mk_req(FUNC_SEARCH, 0, 0, 0, 0, 1023), 1, '{0, 0, 0, 0}});
    dir_rows.push_back('{mk_req(FUNC_UNUSED, 1023, 1023, -1, 1023, 1023), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_ADD, 2, 3, 7, 0, 0), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_ADD, 4, 3, 100, 0, 0), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_ADD, 1023, 4, 32767, 0, 0), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_SEARCH, 0, 0, 0, 4, 2), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_SEARCH, 0, 0, 0, 1023, 2), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_SEARCH, 0, 0, 0, 2, 9), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_CLEAR, 0, 0, 0, 0, 0), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_SEARCH, 0, 0, 0, 2, 3), 1, '{0, 0, 0, 0}});
    // negative self-loop
    dir_rows.push_back('{mk_req(FUNC_ADD, 5, 5, -1, 0, 0), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_SEARCH, 0, 0, 0, 5, 5), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_CLEAR, 0, 0, 0, 0, 0), 0, '{default: 0}});
    // a negative undirected edge ping-pongs into a cycle
    dir_rows.push_back('{mk_req(FUNC_ADD, 0, 1023, -32768, 0, 0), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_ADD, 1023, 0, 32767, 0, 0), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_SEARCH, 0, 0, 0, 1023, 0), 0, '{default: 0}});
    dir_rows.push_back('{mk_req(FUNC_CLEAR, 0, 0, 0, 0, 0), 0, '{default: 0}});
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    drain();

    // fill the edge store past its end, then check the dropped flag and its clear
    write_node_count(2);
    send_req(mk_req(FUNC_ADD, 0, 1, 3, 0, 0));
    for (int i = 0; i < MAX_EDGES_DEF; i++)
      send_req(mk_req(FUNC_ADD, $urandom_range(1023), $urandom_range(1023),
                      $urandom_range(32767), 0, 0));
    send_req(mk_req(FUNC_SEARCH, 0, 0, 0, 1, 0));
    send_req(mk_req(FUNC_CLEAR, 0, 0, 0, 0, 0));
    send_req(mk_req(FUNC_SEARCH, 0, 0, 0, 0, 1));
    drain();

    for (int p = 0; p < 6; p++) begin
      write_node_count(ph_nodes[p]);
      send_idle_pct  = ph_idle[p % 4];
      recv_stall_pct = ph_stall[p % 4];
      if (p == 1) hold_cycles = 3000;
      sent = 0;
      while (sent < 190) begin
        if ($urandom_range(9) < 8) begin
          if ($urandom_range(3) != 0 || edge_cnt > 40) begin
            send_req(mk_req(FUNC_CLEAR, $urandom_range(1023), $urandom_range(1023),
                            $signed(16'($urandom())), $urandom_range(1023),
                            $urandom_range(1023)));
            sent++;
          end
          k = $urandom_range(1, 12);
          repeat (k) send_req(rand_edge(ph_neg[p]));
          sent += k;
          k = $urandom_range(1, 3);
          repeat (k) send_req(rand_search());
          sent += k;
        end else begin
          case ($urandom_range(3))
            0: send_req(mk_req(FUNC_ADD, $urandom_range(1023), $urandom_range(1023),
                               ph_neg[p] ? $signed(16'($urandom())) : $urandom_range(32767),
                               $urandom_range(1023), $urandom_range(1023)));
            1: send_req(mk_req(FUNC_SEARCH, $urandom_range(1023), $urandom_range(1023),
                               $signed(16'($urandom())), $urandom_range(1023),
                               $urandom_range(1023)));
            2: send_req(mk_req(FUNC_CLEAR, 0, 0, 0, 0, 0));
            default: send_req(mk_req(FUNC_UNUSED, $urandom_range(1023), $urandom_range(1023),
                                     $signed(16'($urandom())), $urandom_range(1023),
                                     $urandom_range(1023)));
          endcase
          sent++;
        end
      end
      drain();
    end

    if (mismatches == 0)
      $display("queue_shortest_path_engine: match");
    else
      $display("queue_shortest_path_engine: mismatch");
    $finish;
  end

endmodule
